// File: sv/iad_pkg.sv
// Shared types, constants and table functions for the IMA ADPCM block decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package iad_pkg;

    localparam int WORD_W      = 32;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = 7;
    localparam int STEP_W      = 15;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int BLK_W       = 14;
    localparam int WLEFT_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS   = 8'd1;

    localparam logic [WORD_W-1:0] TOTAL_RESET = 32'd1;
    localparam logic [BLK_W-1:0]  BLOCK_RESET = 14'd64;
    localparam logic [BLK_W-1:0]  BLOCK_MAX   = 14'd8192;
    localparam logic [IDX_W-1:0]  IDX_MAX     = 7'd88;

    localparam logic signed [SAMPLE_W+1:0] PRED_MIN = -18'sd32768;
    localparam logic signed [SAMPLE_W+1:0] PRED_MAX = 18'sd32767;

    // One queued request: the word and what the back end must do with it.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_hdr;
        logic [2:0]        last_nib;  // index of the last code to decode
        logic              eos;       // last sample of this word ends the stream
    } t_cmd;

    function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            7'd0: s = 15'd7;      7'd1: s = 15'd8;      7'd2: s = 15'd9;
            7'd3: s = 15'd10;     7'd4: s = 15'd11;     7'd5: s = 15'd12;
            7'd6: s = 15'd13;     7'd7: s = 15'd14;     7'd8: s = 15'd16;
            7'd9: s = 15'd17;     7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Step index update: codes 0..3 step down by one, 4..7 up by 2, 4, 6, 8.
    function automatic logic [IDX_W-1:0] index_next(input logic [IDX_W-1:0] idx,
                                                    input logic [2:0] mag);
        logic [IDX_W:0] up;
        logic [IDX_W-1:0] r;
        up = {1'b0, idx} + {5'd0, mag[1:0], 1'b0} + 8'd2;
        if (!mag[2]) begin
            r = (idx == '0) ? '0 : idx - 7'd1;
        end else begin
            r = (up > {1'b0, IDX_MAX}) ? IDX_MAX : up[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/iad_front.sv
// Front end: takes words, tracks block position and sample budget, queues requests.
// Depends on iad_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iad_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [iad_pkg::WORD_W-1:0]   i_data_word,
    input  wire                          i_cfg_valid,
    input  wire  [iad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [iad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                          i_q_full,
    output logic                         o_push,
    output iad_pkg::t_cmd                o_cmd
);
    import iad_pkg::*;

    logic [BLK_W-1:0]   r_blk, n_blk;
    logic [WORD_W-1:0]  r_left, n_left;
    logic [WLEFT_W-1:0] r_wleft, n_wleft;
    logic               r_fin, n_fin;

    logic               acc;
    logic               hdr;
    logic [3:0]         cnt;
    logic [WLEFT_W-1:0] blk_left;

    assign o_ready = r_fin || !i_q_full;
    assign acc     = i_valid && o_ready;
    assign hdr     = (r_wleft == '0);
    assign o_push  = acc && !r_fin;

    always_comb begin
        if (r_blk == '0) begin
            blk_left = '0;
        end else if (r_blk > BLOCK_MAX) begin
            blk_left = WLEFT_W'(BLOCK_MAX - 14'd1);
        end else begin
            blk_left = WLEFT_W'(r_blk - 14'd1);
        end
        if (hdr) begin
            cnt = 4'd1;
        end else if (r_left >= 32'd8) begin
            cnt = 4'd8;
        end else begin
            cnt = r_left[3:0];
        end
        o_cmd.word     = i_data_word;
        o_cmd.is_hdr   = hdr;
        o_cmd.last_nib = 3'(cnt - 4'd1);
        o_cmd.eos      = (r_left == {28'd0, cnt});
    end

    always_comb begin
        n_blk   = r_blk;
        n_left  = r_left;
        n_wleft = r_wleft;
        n_fin   = r_fin;
        if (o_push) begin
            n_left  = r_left - {28'd0, cnt};
            n_fin   = o_cmd.eos;
            n_wleft = hdr ? blk_left : r_wleft - 13'd1;
        end
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TOTAL_SAMPLES: begin
                    // restart the stream: next word is a header
                    n_left  = i_cfg_data;
                    n_fin   = (i_cfg_data == '0);
                    n_wleft = '0;
                end
                REG_BLOCK_WORDS: n_blk = i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk   <= BLOCK_RESET;
            r_left  <= TOTAL_RESET;
            r_wleft <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_blk   <= n_blk;
            r_left  <= n_left;
            r_wleft <= n_wleft;
            r_fin   <= n_fin;
        end
    end

endmodule
`default_nettype wire

// File: sv/iad_fifo.sv
// Two-entry request queue between front and back end.
// Depends on iad_pkg (t_cmd).
`timescale 1ns / 1ps
`default_nettype none
module iad_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  iad_pkg::t_cmd  i_data,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output iad_pkg::t_cmd  o_data
);
    import iad_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/iad_back.sv
// Back end: decodes one code per cycle unless the output stalls; registered output.
// Depends on iad_pkg (t_cmd, step table, index update).
`timescale 1ns / 1ps
`default_nettype none
module iad_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_q_valid,
    input  iad_pkg::t_cmd                  i_q_cmd,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic signed [iad_pkg::SAMPLE_W-1:0] o_sample,
    output logic                           o_end_of_run,
    output logic                           o_end_of_stream
);
    import iad_pkg::*;

    logic                       r_busy;
    t_cmd                       r_cmd;
    logic [2:0]                 r_nib;
    logic signed [SAMPLE_W-1:0] r_pred, n_pred;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_sample;
    logic                       r_o_eor, r_o_eos;

    logic                       fire, last;
    logic [3:0]                 code;
    logic [STEP_W+3:0]          prod;
    logic [SAMPLE_W-1:0]        diff;
    logic signed [SAMPLE_W+1:0] sum;
    logic [7:0]                 hdr_idx;

    assign fire  = r_busy && (!r_o_valid || i_ready);
    assign last  = (r_nib == r_cmd.last_nib);
    assign o_pop = i_q_valid && (!r_busy || (fire && last));

    always_comb begin
        code    = r_cmd.word[{r_nib, 2'b00} +: 4];
        prod    = {15'd0, code[2:0], 1'b1} * {4'd0, step_of(r_idx)};
        diff    = prod[STEP_W+3:3];
        hdr_idx = r_cmd.word[23:16];
        if (code[3]) begin
            sum = 18'(r_pred) - $signed({2'b00, diff});
        end else begin
            sum = 18'(r_pred) + $signed({2'b00, diff});
        end
        if (r_cmd.is_hdr) begin
            n_pred = $signed(r_cmd.word[SAMPLE_W-1:0]);
            n_idx  = (hdr_idx > {1'b0, IDX_MAX}) ? IDX_MAX : hdr_idx[IDX_W-1:0];
        end else begin
            // clamp to the 16-bit range
            if (sum < PRED_MIN) begin
                n_pred = PRED_MIN[SAMPLE_W-1:0];
            end else if (sum > PRED_MAX) begin
                n_pred = PRED_MAX[SAMPLE_W-1:0];
            end else begin
                n_pred = sum[SAMPLE_W-1:0];
            end
            n_idx = index_next(r_idx, code[2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (fire) begin
            r_pred     <= n_pred;
            r_idx      <= n_idx;
            r_o_sample <= n_pred;
            r_o_eor    <= last;
            r_o_eos    <= last && r_cmd.eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_nib     <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_nib  <= 3'd0;
            end else if (fire) begin
                r_busy <= !last;
                r_nib  <= last ? 3'd0 : r_nib + 3'd1;
            end
            if (fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_sample        = r_o_sample;
    assign o_end_of_run    = r_o_eor;
    assign o_end_of_stream = r_o_eos;

endmodule
`default_nettype wire

// File: sv/ima_adpcm_block_decoder.sv
// Top level of the mono IMA ADPCM block decoder: front end, request queue, back end.
// Depends on iad_pkg, iad_front, iad_fifo and iad_back.
`timescale 1ns / 1ps
`default_nettype none
// Feed the data chunk one 32-bit little-endian word per request. The first word of
// each block is a header and gives one sample; every other word gives eight samples
// (fewer on the word that reaches total_samples), low nibble first, at one sample
// per cycle while the output is not stalled. The back-end decoder turns one code a
// cycle unless its output stalls: each code needs the predictor and step index left
// by the one before. A two-entry queue lets the front end take the next words while
// samples still drain, and the registered output holds a sample until it is taken.
// Words that arrive after the last sample are taken one a cycle and dropped. Write
// registers only while idle: index 0 is total_samples (a write restarts decoding at
// a header word), index 1 is block_words (read when a header arrives; zero counts
// as one, above 8192 counts as 8192).
module ima_adpcm_block_decoder (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [iad_pkg::WORD_W-1:0]      i_data_word,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic signed [iad_pkg::SAMPLE_W-1:0] o_sample,
    output logic                            o_end_of_run,
    output logic                            o_end_of_stream,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [iad_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [iad_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import iad_pkg::*;

    logic q_full, q_valid, push, pop;
    t_cmd push_cmd, pop_cmd;

    // registers are plain flops: take every write at once
    assign o_cfg_ready = 1'b1;

    iad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_word (i_data_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    iad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_cmd)
    );

    iad_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_cmd         (pop_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample        (o_sample),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_stream (o_end_of_stream)
    );

endmodule
`default_nettype wire

// File: sv/iad_checker.sv
// Port-level assertions for the IMA ADPCM block decoder, bound to its top level.
// Depends on iad_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none
module iad_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_valid,
    input wire                            i_ready,
    input wire [iad_pkg::SAMPLE_W-1:0]    o_sample,
    input wire                            o_end_of_run,
    input wire                            o_end_of_stream
);
    import iad_pkg::*;

    // drop any pending sample on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // hold a stalled sample and its flags
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample)
            && $stable(o_end_of_run) && $stable(o_end_of_stream))
        else $error("stalled sample changed");

    // the stream ends on the last sample of a word
    a_eos_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_stream |-> o_end_of_run)
        else $error("end of stream without end of run");

    // nothing follows the final sample right away
    a_quiet_after_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_end_of_stream |=> !o_valid)
        else $error("sample after end of stream");

endmodule

bind ima_adpcm_block_decoder iad_checker u_iad_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_sample        (o_sample),
    .o_end_of_run    (o_end_of_run),
    .o_end_of_stream (o_end_of_stream)
);
`default_nettype wire
